### rtl/core/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/qalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 8;
   localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
   localparam int MAG_W     = 2 * WORD_BITS - FRAC_BITS;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [2*WORD_BITS-1:0] ROUND_HALF = (2*WORD_BITS)'(1) << (FRAC_BITS - 1);

   localparam logic [MAG_W-1:0] LIMIT_NEG =
      {{(MAG_W-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [MAG_W-1:0] LIMIT_POS = LIMIT_NEG - MAG_W'(1);

   typedef enum logic [3:0] {
      FUNC_ADD     = 4'd0,
      FUNC_SUB     = 4'd1,
      FUNC_MUL     = 4'd2,
      FUNC_DIV     = 4'd3,
      FUNC_EQ      = 4'd4,
      FUNC_NE      = 4'd5,
      FUNC_GT      = 4'd6,
      FUNC_LT      = 4'd7,
      FUNC_GE      = 4'd8,
      FUNC_LE      = 4'd9,
      FUNC_MIN     = 4'd10,
      FUNC_MAX     = 4'd11,
      FUNC_INC     = 4'd12,
      FUNC_DEC     = 4'd13,
      FUNC_TOINT   = 4'd14,
      FUNC_FROMINT = 4'd15
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIV0 = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef struct packed {
      func_type               func;
      logic [WORD_BITS-1:0]   simple_value;
      logic                   compare_true;
      logic [2*WORD_BITS-1:0] prod;
      logic                   neg;
      logic                   a_zero;
      logic                   a_neg;
      logic                   div0;
      logic [WORD_BITS-1:0]   divisor;
      logic [WORD_BITS-1:0]   rem;
      logic [QUO_BITS-1:0]    num;
   } stage_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic                 sat;
   } sat_type;

   // clamp a magnitude to the word range and apply the sign
   function automatic sat_type sat_word(input logic neg, input logic [MAG_W-1:0] mag);
      logic [MAG_W-1:0] limit;
      logic [MAG_W-1:0] clamp;
      sat_type          res;
      limit     = neg ? LIMIT_NEG : LIMIT_POS;
      res.sat   = (mag > limit);
      clamp     = res.sat ? limit : mag;
      res.value = neg ? (~clamp[WORD_BITS-1:0] + WORD_BITS'(1)) : clamp[WORD_BITS-1:0];
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/core/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU.
// Input channel req_*: one word per operation (func, operand_a, operand_b),
// taken when req_valid and req_ready are both high.
// Result channel rsp_*: one word per operation (result_value, compare_true,
// status), delivered in the order the operations were taken.
// Stages from the accepting edge to rsp_valid, in order: one entry stage
// (operand decode, simple ops and the 32x32 magnitude multiply), a chain of
// 40 divide cells that each resolve one quotient bit, and one rounding and
// saturation stage that is also the output register.
// Throughput is one operation per cycle while rsp_ready keeps the output moving;
// every operation walks the full chain, so the divide cell count sets the latency.
// Each stage holds its word until the next stage is free, so while rsp_ready
// is low the block keeps accepting until every stage is full, then drops
// req_ready.
// Synchronous reset empties all stages; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fixed_point_q24_8_alu (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [3:0]                            req_func,
   input  wire logic signed [qalu_pkg::WORD_BITS-1:0] req_operand_a,
   input  wire logic signed [qalu_pkg::WORD_BITS-1:0] req_operand_b,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [qalu_pkg::WORD_BITS-1:0]      rsp_result_value,
   output logic                                       rsp_compare_true,
   output logic [1:0]                                 rsp_status
);

   qalu_pkg::stage_type link_stage [0:qalu_pkg::QUO_BITS];
   logic                link_valid [0:qalu_pkg::QUO_BITS];
   logic                link_ready [0:qalu_pkg::QUO_BITS];
   logic                rsp_clean;
   logic                rsp_div0_legal;

   qalu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (req_ready),
      .up_func      (req_func),
      .up_operand_a (req_operand_a),
      .up_operand_b (req_operand_b),
      .dn_valid     (link_valid[0]),
      .dn_ready     (link_ready[0]),
      .dn_stage     (link_stage[0])
   );

   for (genvar i = 0; i < qalu_pkg::QUO_BITS; i++) begin : g_cell
      qalu_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_stage (link_stage[i]),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_stage (link_stage[i+1])
      );
   end

   qalu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .up_valid         (link_valid[qalu_pkg::QUO_BITS]),
      .up_ready         (link_ready[qalu_pkg::QUO_BITS]),
      .up_stage         (link_stage[qalu_pkg::QUO_BITS]),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_compare_true (rsp_compare_true),
      .rsp_status       (rsp_status)
   );

   assign rsp_clean      = (rsp_result_value == '0) && (rsp_status == qalu_pkg::STATUS_OK);
   assign rsp_div0_legal = (rsp_result_value == '0) ||
                           (rsp_result_value == qalu_pkg::WORD_MAX) ||
                           (rsp_result_value == qalu_pkg::WORD_MIN);

   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `ASSERT_IMPLY(a_compare_clean, clock, reset, rsp_valid && rsp_compare_true, rsp_clean)
   `ASSERT_IMPLY(a_div0_value, clock, reset, rsp_valid && rsp_status == qalu_pkg::STATUS_DIV0, rsp_div0_legal)

endmodule

`default_nettype wire

### rtl/core/qalu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module qalu_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 up_valid,
   output logic                                      up_ready,
   input  wire logic [3:0]                           up_func,
   input  wire logic signed [qalu_pkg::WORD_BITS-1:0] up_operand_a,
   input  wire logic signed [qalu_pkg::WORD_BITS-1:0] up_operand_b,
   output logic                                      dn_valid,
   input  wire logic                                 dn_ready,
   output qalu_pkg::stage_type                       dn_stage
);

   qalu_pkg::func_type  func;
   logic [qalu_pkg::WORD_BITS-1:0] a_mag;
   logic [qalu_pkg::WORD_BITS-1:0] b_mag;
   logic                a_lt_b;
   logic                b_lt_a;
   qalu_pkg::stage_type calc;
   qalu_pkg::stage_type stage_ff;
   qalu_pkg::stage_type stage_in;
   logic                valid_ff;
   logic                valid_in;

   assign func   = qalu_pkg::func_type'(up_func);
   assign a_mag  = up_operand_a[qalu_pkg::WORD_BITS-1] ?
                   (~up_operand_a + qalu_pkg::WORD_BITS'(1)) : up_operand_a;
   assign b_mag  = up_operand_b[qalu_pkg::WORD_BITS-1] ?
                   (~up_operand_b + qalu_pkg::WORD_BITS'(1)) : up_operand_b;
   assign a_lt_b = (up_operand_a < up_operand_b);
   assign b_lt_a = (up_operand_b < up_operand_a);

   always_comb begin
      calc              = '0;
      calc.func         = func;
      calc.prod         = (2*qalu_pkg::WORD_BITS)'(a_mag) * (2*qalu_pkg::WORD_BITS)'(b_mag);
      calc.neg          = up_operand_a[qalu_pkg::WORD_BITS-1] ^ up_operand_b[qalu_pkg::WORD_BITS-1];
      calc.a_zero       = (up_operand_a == '0);
      calc.a_neg        = up_operand_a[qalu_pkg::WORD_BITS-1];
      calc.div0         = (up_operand_b == '0);
      calc.divisor      = b_mag;
      calc.rem          = '0;
      calc.num          = {a_mag, {qalu_pkg::FRAC_BITS{1'b0}}};
      case (func)
         qalu_pkg::FUNC_ADD:     calc.simple_value = up_operand_a + up_operand_b;
         qalu_pkg::FUNC_SUB:     calc.simple_value = up_operand_a - up_operand_b;
         qalu_pkg::FUNC_EQ:      calc.compare_true = (up_operand_a == up_operand_b);
         qalu_pkg::FUNC_NE:      calc.compare_true = (up_operand_a != up_operand_b);
         qalu_pkg::FUNC_GT:      calc.compare_true = b_lt_a;
         qalu_pkg::FUNC_LT:      calc.compare_true = a_lt_b;
         qalu_pkg::FUNC_GE:      calc.compare_true = !a_lt_b;
         qalu_pkg::FUNC_LE:      calc.compare_true = !b_lt_a;
         qalu_pkg::FUNC_MIN:     calc.simple_value = a_lt_b ? up_operand_a : up_operand_b;
         qalu_pkg::FUNC_MAX:     calc.simple_value = b_lt_a ? up_operand_a : up_operand_b;
         qalu_pkg::FUNC_INC:     calc.simple_value = up_operand_a + qalu_pkg::WORD_BITS'(1);
         qalu_pkg::FUNC_DEC:     calc.simple_value = up_operand_a - qalu_pkg::WORD_BITS'(1);
         qalu_pkg::FUNC_TOINT:   calc.simple_value = up_operand_a >>> qalu_pkg::FRAC_BITS;
         qalu_pkg::FUNC_FROMINT: calc.simple_value = up_operand_a << qalu_pkg::FRAC_BITS;
         default:                calc.simple_value = '0;
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      stage_in = (up_ready && up_valid) ? calc : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

`default_nettype wire

### rtl/core/qalu_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module qalu_div_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                up_valid,
   output logic                     up_ready,
   input  wire qalu_pkg::stage_type up_stage,
   output logic                     dn_valid,
   input  wire logic                dn_ready,
   output qalu_pkg::stage_type      dn_stage
);

   logic [qalu_pkg::WORD_BITS:0] trial;
   logic [qalu_pkg::WORD_BITS:0] diff;
   logic                         take;
   qalu_pkg::stage_type          step;
   qalu_pkg::stage_type          stage_ff;
   qalu_pkg::stage_type          stage_in;
   logic                         valid_ff;
   logic                         valid_in;

   // one restoring step: shift in the next dividend bit, subtract when it fits
   assign trial = {up_stage.rem, up_stage.num[qalu_pkg::QUO_BITS-1]};
   assign diff  = trial - {1'b0, up_stage.divisor};
   assign take  = (trial >= {1'b0, up_stage.divisor});

   always_comb begin
      step     = up_stage;
      step.rem = take ? diff[qalu_pkg::WORD_BITS-1:0] : trial[qalu_pkg::WORD_BITS-1:0];
      step.num = {up_stage.num[qalu_pkg::QUO_BITS-2:0], take};
   end

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      stage_in = (up_ready && up_valid) ? step : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

`default_nettype wire

### rtl/core/qalu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module qalu_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  up_valid,
   output logic                                       up_ready,
   input  wire qalu_pkg::stage_type                   up_stage,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [qalu_pkg::WORD_BITS-1:0]      rsp_result_value,
   output logic                                       rsp_compare_true,
   output logic [1:0]                                 rsp_status
);

   logic [2*qalu_pkg::WORD_BITS-1:0] mul_sum;
   logic [qalu_pkg::MAG_W-1:0]       mul_mag;
   logic                             div_round;
   logic [qalu_pkg::MAG_W-1:0]       div_mag;
   qalu_pkg::sat_type                mul_sat;
   qalu_pkg::sat_type                div_sat;

   logic [qalu_pkg::WORD_BITS-1:0] value_calc;
   logic                           compare_calc;
   qalu_pkg::status_type           status_calc;

   logic                           valid_ff;
   logic                           valid_in;
   logic [qalu_pkg::WORD_BITS-1:0] value_ff;
   logic [qalu_pkg::WORD_BITS-1:0] value_in;
   logic                           compare_ff;
   logic                           compare_in;
   qalu_pkg::status_type           status_ff;
   qalu_pkg::status_type           status_in;

   assign mul_sum   = up_stage.prod + qalu_pkg::ROUND_HALF;
   assign mul_mag   = qalu_pkg::MAG_W'(mul_sum >> qalu_pkg::FRAC_BITS);
   assign div_round = ({up_stage.rem, 1'b0} >= {1'b0, up_stage.divisor});
   assign div_mag   = qalu_pkg::MAG_W'(up_stage.num) + qalu_pkg::MAG_W'(div_round);
   assign mul_sat   = qalu_pkg::sat_word(up_stage.neg, mul_mag);
   assign div_sat   = qalu_pkg::sat_word(up_stage.neg, div_mag);

   always_comb begin
      value_calc   = up_stage.simple_value;
      compare_calc = up_stage.compare_true;
      status_calc  = qalu_pkg::STATUS_OK;
      case (up_stage.func)
         qalu_pkg::FUNC_MUL: begin
            value_calc  = mul_sat.value;
            status_calc = mul_sat.sat ? qalu_pkg::STATUS_SAT : qalu_pkg::STATUS_OK;
         end
         qalu_pkg::FUNC_DIV: begin
            if (up_stage.div0) begin
               status_calc = qalu_pkg::STATUS_DIV0;
               if (up_stage.a_zero) begin
                  value_calc = '0;
               end else begin
                  value_calc = up_stage.a_neg ? qalu_pkg::WORD_MIN : qalu_pkg::WORD_MAX;
               end
            end else begin
               value_calc  = div_sat.value;
               status_calc = div_sat.sat ? qalu_pkg::STATUS_SAT : qalu_pkg::STATUS_OK;
            end
         end
         default: begin
            value_calc = up_stage.simple_value;
         end
      endcase
   end

   assign up_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in   = up_ready ? up_valid : valid_ff;
      value_in   = (up_ready && up_valid) ? value_calc : value_ff;
      compare_in = (up_ready && up_valid) ? compare_calc : compare_ff;
      status_in  = (up_ready && up_valid) ? status_calc : status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff   <= value_in;
      compare_ff <= compare_in;
      status_ff  <= status_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_value = value_ff;
   assign rsp_compare_true = compare_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire
